FILE: sv/edf_pkg.sv
`default_nettype none

package edf_pkg;

    localparam int MAX_TASKS = 8;
    localparam int TIME_BITS = 16;
    localparam int SLOT_W    = $clog2(MAX_TASKS);
    localparam int CNT_W     = $clog2(MAX_TASKS + 1);
    localparam int MASK_W    = 8;

    typedef logic [TIME_BITS-1:0] time_t;

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_TICK = 1'b1
    } edf_cmd_t;

    typedef struct packed {
        logic        command;
        logic [2:0]  task_index;
        logic [15:0] release_offset;
        logic [15:0] compute_time;
        logic [15:0] relative_deadline;
        logic [15:0] period_length;
    } edf_req_t;

    typedef struct packed {
        logic              running_valid;
        logic [2:0]        running_task;
        logic [MASK_W-1:0] released_mask;
        logic [MASK_W-1:0] missed_mask;
    } edf_rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_CHARGE,
        ST_DONE
    } edf_state_t;

endpackage

`default_nettype wire

FILE: sv/edf_tick_scheduler.sv
`default_nettype none

// Periodic-task earliest-deadline-first scheduler. A load request takes effect at
// its accept edge and its all-zero result strobes on done in the cycle after the
// accept; the block is free again once the strobe is over. A tick request walks
// the N = min(task_count, 8) active slots twice through one per-slot compare and
// decrement unit, one slot per cycle: a release and selection pass, then a charge
// and deadline pass. Its result strobes on done after the charge pass, and the
// next request can be accepted once busy is low again; with no active slot a tick
// goes straight to done. The result is valid for the one cycle done is high; the
// receiver cannot stall it. Write task_count only while busy is low.
module edf_tick_scheduler (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire edf_pkg::edf_req_t req,
    output logic                   busy,
    output logic                   done,
    output edf_pkg::edf_rsp_t      rsp,
    input  wire logic              cfg_we,
    input  wire logic [3:0]        cfg_data
);

    edf_pkg::edf_state_t state_reg, state_next;

    logic [3:0] task_count_reg;

    edf_pkg::time_t stored_compute_reg  [edf_pkg::MAX_TASKS];
    edf_pkg::time_t stored_deadline_reg [edf_pkg::MAX_TASKS];
    edf_pkg::time_t stored_period_reg   [edf_pkg::MAX_TASKS];
    edf_pkg::time_t countdown_reg       [edf_pkg::MAX_TASKS];
    edf_pkg::time_t work_reg            [edf_pkg::MAX_TASKS];
    edf_pkg::time_t dl_left_reg         [edf_pkg::MAX_TASKS];
    logic [edf_pkg::MAX_TASKS-1:0] loaded_reg;

    logic [edf_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [edf_pkg::CNT_W-1:0] active;
    logic [edf_pkg::SLOT_W-1:0] slot;
    logic last_slot;

    logic                        found_reg, found_next;
    logic [edf_pkg::SLOT_W-1:0]  best_reg, best_next;
    edf_pkg::time_t              best_dl_reg, best_dl_next;
    logic [edf_pkg::MASK_W-1:0]  released_reg, released_next;
    logic [edf_pkg::MASK_W-1:0]  missed_reg, missed_next;

    logic accept;
    logic load_we;

    // Per-slot unit signals.
    edf_pkg::time_t cur_cd, cur_work, cur_dl;
    edf_pkg::time_t new_cd, new_work, new_dl;
    logic           slot_we;
    logic           cur_loaded;
    logic           rel_hit;
    logic           in_mask;
    logic [2:0]     mask_idx;

    assign accept    = start && !busy;
    assign load_we   = accept && (req.command == edf_pkg::CMD_LOAD)
                       && (32'(req.task_index) < edf_pkg::MAX_TASKS);
    assign active    = (32'(task_count_reg) > edf_pkg::MAX_TASKS)
                       ? edf_pkg::CNT_W'(edf_pkg::MAX_TASKS)
                       : edf_pkg::CNT_W'(task_count_reg);
    assign slot      = cnt_reg[edf_pkg::SLOT_W-1:0];
    assign last_slot = (edf_pkg::CNT_W'(cnt_reg + 1'b1) == active);
    assign cur_cd     = countdown_reg[slot];
    assign cur_work   = work_reg[slot];
    assign cur_dl     = dl_left_reg[slot];
    assign cur_loaded = loaded_reg[slot];
    assign in_mask    = (32'(slot) < edf_pkg::MASK_W);
    assign mask_idx   = 3'(slot);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= edf_pkg::ST_IDLE;
            task_count_reg <= '0;
            cnt_reg        <= '0;
            found_reg      <= 1'b0;
            best_reg       <= '0;
            best_dl_reg    <= '0;
            released_reg   <= '0;
            missed_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            found_reg    <= found_next;
            best_reg     <= best_next;
            best_dl_reg  <= best_dl_next;
            released_reg <= released_next;
            missed_reg   <= missed_next;
            if (cfg_we)
            begin
                task_count_reg <= cfg_data;
            end
        end
    end

    // Task parameters need no reset; they are only read for loaded slots.
    always_ff @(posedge clk)
    begin
        if (load_we)
        begin
            stored_compute_reg[req.task_index]  <= edf_pkg::TIME_BITS'(req.compute_time);
            stored_deadline_reg[req.task_index] <=
                edf_pkg::TIME_BITS'(req.relative_deadline);
            stored_period_reg[req.task_index]   <= edf_pkg::TIME_BITS'(req.period_length);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < edf_pkg::MAX_TASKS; i++)
            begin
                countdown_reg[i] <= '0;
                work_reg[i]      <= '0;
                dl_left_reg[i]   <= '0;
            end
            loaded_reg <= '0;
        end
        else if (load_we)
        begin
            countdown_reg[req.task_index] <= edf_pkg::TIME_BITS'(req.release_offset);
            work_reg[req.task_index]      <= '0;
            dl_left_reg[req.task_index]   <= '0;
            loaded_reg[req.task_index]    <= 1'b1;
        end
        else if (slot_we)
        begin
            countdown_reg[slot] <= new_cd;
            work_reg[slot]      <= new_work;
            dl_left_reg[slot]   <= new_dl;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        found_next    = found_reg;
        best_next     = best_reg;
        best_dl_next  = best_dl_reg;
        released_next = released_reg;
        missed_next   = missed_reg;
        new_cd        = cur_cd;
        new_work      = cur_work;
        new_dl        = cur_dl;
        slot_we       = 1'b0;
        rel_hit       = 1'b0;
        busy          = (state_reg != edf_pkg::ST_IDLE);
        done          = (state_reg == edf_pkg::ST_DONE);

        unique case (state_reg)
            edf_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    cnt_next      = '0;
                    found_next    = 1'b0;
                    best_next     = '0;
                    best_dl_next  = '0;
                    released_next = '0;
                    missed_next   = '0;
                    if (req.command == edf_pkg::CMD_TICK && active != '0)
                    begin
                        state_next = edf_pkg::ST_SCAN;
                    end
                    else
                    begin
                        state_next = edf_pkg::ST_DONE;
                    end
                end
            end

            edf_pkg::ST_SCAN:
            begin
                // Release a new job if the countdown expired, then offer the slot
                // to the running earliest-deadline comparison.
                rel_hit = cur_loaded && (cur_cd == '0);
                if (rel_hit)
                begin
                    new_work = stored_compute_reg[slot];
                    new_dl   = stored_deadline_reg[slot];
                    new_cd   = stored_period_reg[slot];
                    slot_we  = 1'b1;
                    if (in_mask)
                    begin
                        released_next[mask_idx] = 1'b1;
                        if (cur_work != '0)
                        begin
                            missed_next[mask_idx] = 1'b1;
                        end
                    end
                end
                if (cur_loaded && new_work != '0 && (!found_reg || new_dl < best_dl_reg))
                begin
                    found_next   = 1'b1;
                    best_next    = slot;
                    best_dl_next = new_dl;
                end
                if (last_slot)
                begin
                    cnt_next   = '0;
                    state_next = edf_pkg::ST_CHARGE;
                end
                else
                begin
                    cnt_next = edf_pkg::CNT_W'(cnt_reg + 1'b1);
                end
            end

            edf_pkg::ST_CHARGE:
            begin
                if (cur_loaded)
                begin
                    slot_we = 1'b1;
                    if (found_reg && slot == best_reg)
                    begin
                        new_work = cur_work - 1'b1;
                    end
                    if (cur_cd != '0)
                    begin
                        new_cd = cur_cd - 1'b1;
                    end
                    if (new_work != '0)
                    begin
                        if (cur_dl != '0)
                        begin
                            new_dl = cur_dl - 1'b1;
                        end
                        if (new_dl == '0)
                        begin
                            new_work = '0;
                            if (in_mask)
                            begin
                                missed_next[mask_idx] = 1'b1;
                            end
                        end
                    end
                end
                if (last_slot)
                begin
                    cnt_next   = '0;
                    state_next = edf_pkg::ST_DONE;
                end
                else
                begin
                    cnt_next = edf_pkg::CNT_W'(cnt_reg + 1'b1);
                end
            end

            edf_pkg::ST_DONE:
            begin
                state_next = edf_pkg::ST_IDLE;
            end

            default:
            begin
                state_next = edf_pkg::ST_IDLE;
            end
        endcase
    end

    assign rsp.running_valid = found_reg;
    assign rsp.running_task  = found_reg ? 3'(best_reg) : 3'd0;
    assign rsp.released_mask = released_reg;
    assign rsp.missed_mask   = missed_reg;

endmodule

`default_nettype wire

FILE: sv/edf_checker.sv
`default_nettype none

module edf_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              start,
    input wire logic              busy,
    input wire logic              done,
    input wire edf_pkg::edf_rsp_t rsp
);

    // A result strobe lasts exactly one cycle.
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

    // An accepted request makes the block busy.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but busy not raised");

    // The block frees itself right after delivering a result.
    a_done_frees: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("busy still high after result");

    // Busy only drops after a result was shown.
    a_fall_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> $past(done))
        else $error("busy dropped without a result");

    // With no task running, the task field is zero.
    a_idle_task: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !rsp.running_valid) |-> (rsp.running_task == 3'd0))
        else $error("running_task nonzero without a running task");

endmodule

bind edf_tick_scheduler edf_checker u_edf_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .rsp   (rsp)
);

`default_nettype wire
